FILE: hdl/source_text_tokenizer_assert.svh
// Assertion macros for the tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// cond must hold at every edge out of reset
`define STT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tokenizer assertion failed");

// ante at one edge implies cons at the next edge
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

FILE: hdl/stt_pkg.sv
package stt_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};

    // text bytes kept per token and saturation of the byte count
    localparam int WORD_BYTES = 8;
    localparam logic [3:0] WORD_LEN_MAX = 4'd15;

    // token queue depth, a power of two, at least two
    localparam int TOK_DEPTH = 4;

    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_DOT        = 8'h2e;
    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5c;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_EQUAL      = 8'h3d;

    typedef enum logic [2:0] {
        K_IDENT   = 3'd0,
        K_KEYWORD = 3'd1,
        K_NUMBER  = 3'd2,
        K_STRING  = 3'd3,
        K_OPER    = 3'd4,
        K_PUNCT   = 3'd5,
        K_UNKNOWN = 3'd6,
        K_EOF     = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] length;
        logic [15:0]            text;
        logic                   last;
    } token_t;

    // keyword text, first byte lowest (strings written back to front)
    localparam int KW_COUNT = 21;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("rav"),      64'("nuf"),    64'("ssalc"),  64'("mune"),
        64'("fi"),       64'("esle"),   64'("rof"),    64'("elihw"),
        64'("kaerb"),    64'("eunitnoc"), 64'("nruter"), 64'("tel"),
        64'("tni"),      64'("tniu"),   64'("taolf"),  64'("loob"),
        64'("gnirts"),   64'("hctiws"), 64'("esac"),   64'("tluafed"),
        64'("tsnoc")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd6,
        4'd3, 4'd3, 4'd4, 4'd5, 4'd4, 4'd6, 4'd6, 4'd4, 4'd7, 4'd5
    };

    // bytes past the count are always zero, so a full compare suffices
    function automatic logic is_keyword(input logic [63:0] wbuf, input logic [3:0] wlen);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (wbuf == KW_TEXT[i] && wlen == KW_LEN[i])
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

FILE: hdl/source_text_tokenizer.sv
// Source text tokenizer.
// Input channel item_valid/item_ready carries one word per cycle: action 0
// with a source byte in byte_value, or action 1 for end of input.
// Output channel token_valid/token_ready carries tokens: kind, start line
// and column, text offset and length, up to two text bytes, and last, which
// marks the final token caused by one input word.
// Lexer state and position counters update in the cycle a word is accepted;
// its zero, one or two tokens go into a four-entry token queue, and the
// first appears on the output next cycle if the queue was empty.
// Throughput is one input word per cycle while item_ready is high. The
// queue drains one token per cycle, so two-token words make it fill up;
// item_ready drops while fewer than two queue entries are free.
// When the receiver stalls, the queue fills and then holds the input back;
// no token is lost or reordered.
// Reset empties the queue, returns the lexer to idle between tokens, and
// sets line and column to 1 and the byte offset to 0. After end of input
// the counters keep counting from where they stopped.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic                   action,
    input  logic [7:0]             byte_value,
    output logic                   token_valid,
    input  logic                   token_ready,
    output logic [2:0]             token_kind,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [COLUMN_BITS-1:0] start_column,
    output logic [OFFSET_BITS-1:0] text_offset,
    output logic [OFFSET_BITS-1:0] text_length,
    output logic [15:0]            short_text,
    output logic                   last
);

    `include "source_text_tokenizer_assert.svh"

    localparam int PTR_BITS = $clog2(TOK_DEPTH);
    localparam int CNT_BITS = $clog2(TOK_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(TOK_DEPTH);
    localparam logic [CNT_BITS-1:0] CNT_ROOM2 = CNT_BITS'(TOK_DEPTH - 2);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OPER, M_IDENT,
        M_NUMBER, M_FRACTION, M_STRING, M_STRING_ESC
    } mode_t;

    function automatic logic is_space(input logic [7:0] ch);
        return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic is_oper(input logic [7:0] ch);
        return ch == "+" || ch == "-" || ch == "*" || ch == "/" || ch == "=" ||
               ch == "!" || ch == "<" || ch == ">" || ch == "&" || ch == "|" ||
               ch == "^" || ch == "%";
    endfunction

    function automatic logic may_pair(input logic [7:0] ch);
        return ch == "=" || ch == "!" || ch == "<" || ch == ">" || ch == "&" ||
               ch == "|";
    endfunction

    function automatic logic pairs_with(input logic [7:0] a, input logic [7:0] b);
        logic p;
        if (b == CH_EQUAL)
            p = a == "=" || a == "!" || a == "<" || a == ">";
        else
            p = (a == b) && (a == "&" || a == "|" || a == "<" || a == ">");
        return p;
    endfunction

    function automatic logic is_punct(input logic [7:0] ch);
        return ch == "(" || ch == ")" || ch == "{" || ch == "}" || ch == "[" ||
               ch == "]" || ch == "," || ch == ":" || ch == ";" || ch == CH_DOT;
    endfunction

    // returns {count, buffer} with ch added
    function automatic logic [67:0] append_byte(input logic [63:0] wbuf,
                                                input logic [3:0] wlen,
                                                input logic [7:0] ch);
        logic [63:0] b;
        logic [3:0]  n;
        b = wbuf;
        n = wlen;
        if (wlen < 4'(WORD_BYTES))
            b[{wlen[2:0], 3'b000} +: 8] = ch;
        if (wlen < WORD_LEN_MAX)
            n = wlen + 4'd1;
        return {n, b};
    endfunction

    function automatic token_t make_tok(input kind_t k,
                                        input logic [LINE_BITS-1:0] ln,
                                        input logic [COLUMN_BITS-1:0] col,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [OFFSET_BITS-1:0] len,
                                        input logic [15:0] txt);
        token_t t;
        t.kind   = k;
        t.line   = ln;
        t.column = col;
        t.offset = off;
        t.length = len;
        t.text   = txt;
        t.last   = 1'b0;
        return t;
    endfunction

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_column_reg, tok_column_next;
    logic [OFFSET_BITS-1:0] tok_offset_reg, tok_offset_next;
    logic [63:0]            wbuf_reg, wbuf_next;
    logic [3:0]             wlen_reg, wlen_next;
    logic [7:0]             pending_reg, pending_next;

    token_t                 queue_reg [TOK_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    token_t                 tok_a, tok_b, first_tok, second_tok;
    logic                   tok_a_vld, tok_b_vld;
    logic                   again;
    logic [OFFSET_BITS-1:0] open_len;
    logic                   kw_hit;
    logic                   accept, pop;
    logic [1:0]             push_n;
    logic [7:0]             ch;
    token_t                 head;

    assign ch       = byte_value;
    assign accept   = item_valid && item_ready;
    assign pop      = token_valid && token_ready;
    assign open_len = (offset_reg >= tok_offset_reg) ? offset_reg - tok_offset_reg
                                                     : '0;
    assign kw_hit   = is_keyword(wbuf_reg, wlen_reg);

    always_comb
    begin
        mode_next       = mode_reg;
        line_next       = line_reg;
        column_next     = column_reg;
        offset_next     = offset_reg;
        tok_line_next   = tok_line_reg;
        tok_column_next = tok_column_reg;
        tok_offset_next = tok_offset_reg;
        wbuf_next       = wbuf_reg;
        wlen_next       = wlen_reg;
        pending_next    = pending_reg;
        tok_a           = '0;
        tok_b           = '0;
        tok_a_vld       = 1'b0;
        tok_b_vld       = 1'b0;
        again           = 1'b0;

        if (action) begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    tok_a = make_tok(K_OPER, tok_line_reg, tok_column_reg, tok_offset_reg,
                                     OFFSET_BITS'(1), {8'h00, CH_SLASH});
                    tok_a_vld = 1'b1;
                end
                M_OPER:
                begin
                    tok_a = make_tok(K_OPER, tok_line_reg, tok_column_reg, tok_offset_reg,
                                     OFFSET_BITS'(1), {8'h00, pending_reg});
                    tok_a_vld = 1'b1;
                end
                M_IDENT:
                begin
                    tok_a = make_tok(kw_hit ? K_KEYWORD : K_IDENT, tok_line_reg,
                                     tok_column_reg, tok_offset_reg, open_len,
                                     wbuf_reg[15:0]);
                    tok_a_vld = 1'b1;
                end
                M_NUMBER, M_FRACTION:
                begin
                    tok_a = make_tok(K_NUMBER, tok_line_reg, tok_column_reg, tok_offset_reg,
                                     open_len, wbuf_reg[15:0]);
                    tok_a_vld = 1'b1;
                end
                M_STRING, M_STRING_ESC:
                begin
                    // unterminated string
                    tok_a = make_tok(K_UNKNOWN, tok_line_reg, tok_column_reg,
                                     tok_offset_reg, '0, 16'h0000);
                    tok_a_vld = 1'b1;
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
            tok_b = make_tok(K_EOF, line_reg, column_reg, offset_reg, '0, 16'h0000);
            tok_b_vld = 1'b1;
        end else begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    if (ch == CH_SLASH) begin
                        mode_next = M_COMMENT;
                    end else begin
                        tok_a = make_tok(K_OPER, tok_line_reg, tok_column_reg,
                                         tok_offset_reg, OFFSET_BITS'(1),
                                         {8'h00, CH_SLASH});
                        tok_a_vld = 1'b1;
                        again = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (ch == CH_NEWLINE)
                        mode_next = M_IDLE;
                end
                M_OPER:
                begin
                    if (pairs_with(pending_reg, ch)) begin
                        tok_a = make_tok(K_OPER, tok_line_reg, tok_column_reg,
                                         tok_offset_reg, OFFSET_BITS'(2), {ch, pending_reg});
                        mode_next = M_IDLE;
                    end else begin
                        tok_a = make_tok(K_OPER, tok_line_reg, tok_column_reg,
                                         tok_offset_reg, OFFSET_BITS'(1),
                                         {8'h00, pending_reg});
                        again = 1'b1;
                    end
                    tok_a_vld = 1'b1;
                end
                M_IDENT:
                begin
                    if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDERSCORE) begin
                        {wlen_next, wbuf_next} = append_byte(wbuf_reg, wlen_reg, ch);
                    end else begin
                        tok_a = make_tok(kw_hit ? K_KEYWORD : K_IDENT, tok_line_reg,
                                         tok_column_reg, tok_offset_reg, open_len,
                                         wbuf_reg[15:0]);
                        tok_a_vld = 1'b1;
                        again = 1'b1;
                    end
                end
                M_NUMBER, M_FRACTION:
                begin
                    if (is_digit(ch)) begin
                        {wlen_next, wbuf_next} = append_byte(wbuf_reg, wlen_reg, ch);
                    end else if (ch == CH_DOT && mode_reg == M_NUMBER) begin
                        {wlen_next, wbuf_next} = append_byte(wbuf_reg, wlen_reg, ch);
                        mode_next = M_FRACTION;
                    end else begin
                        tok_a = make_tok(K_NUMBER, tok_line_reg, tok_column_reg,
                                         tok_offset_reg, open_len, wbuf_reg[15:0]);
                        tok_a_vld = 1'b1;
                        again = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (ch == CH_QUOTE) begin
                        tok_a = make_tok(K_STRING, tok_line_reg, tok_column_reg,
                                         tok_offset_reg, open_len, wbuf_reg[15:0]);
                        tok_a_vld = 1'b1;
                        mode_next = M_IDLE;
                    end else begin
                        {wlen_next, wbuf_next} = append_byte(wbuf_reg, wlen_reg, ch);
                        if (ch == CH_BACKSLASH)
                            mode_next = M_STRING_ESC;
                    end
                end
                M_STRING_ESC:
                begin
                    {wlen_next, wbuf_next} = append_byte(wbuf_reg, wlen_reg, ch);
                    mode_next = M_STRING;
                end
                default:
                begin
                    again = 1'b1;
                end
            endcase

            // byte starts a new token from the idle state
            if (again) begin
                mode_next = M_IDLE;
                if (is_space(ch)) begin
                end else if (ch == CH_SLASH || is_alpha(ch) || ch == CH_UNDERSCORE ||
                             is_digit(ch) || ch == CH_QUOTE ||
                             (is_oper(ch) && may_pair(ch))) begin
                    tok_line_next   = line_reg;
                    tok_column_next = column_reg;
                    tok_offset_next = offset_reg;
                    wbuf_next       = '0;
                    wlen_next       = '0;
                    if (ch == CH_SLASH) begin
                        mode_next = M_SLASH;
                    end else if (is_alpha(ch) || ch == CH_UNDERSCORE) begin
                        {wlen_next, wbuf_next} = append_byte('0, '0, ch);
                        mode_next = M_IDENT;
                    end else if (is_digit(ch)) begin
                        {wlen_next, wbuf_next} = append_byte('0, '0, ch);
                        mode_next = M_NUMBER;
                    end else if (ch == CH_QUOTE) begin
                        tok_offset_next = (offset_reg != OFFSET_MAX) ? offset_reg + 1'b1
                                                                     : OFFSET_MAX;
                        mode_next = M_STRING;
                    end else begin
                        pending_next = ch;
                        mode_next = M_OPER;
                    end
                end else if (is_oper(ch)) begin
                    tok_b = make_tok(K_OPER, line_reg, column_reg, offset_reg,
                                     OFFSET_BITS'(1), {8'h00, ch});
                    tok_b_vld = 1'b1;
                end else if (is_punct(ch)) begin
                    tok_b = make_tok(K_PUNCT, line_reg, column_reg, offset_reg,
                                     OFFSET_BITS'(1), {8'h00, ch});
                    tok_b_vld = 1'b1;
                end else begin
                    tok_b = make_tok(K_UNKNOWN, line_reg, column_reg, offset_reg,
                                     '0, 16'h0000);
                    tok_b_vld = 1'b1;
                end
            end

            if (offset_reg != OFFSET_MAX)
                offset_next = offset_reg + 1'b1;
            if (ch == CH_NEWLINE) begin
                if (line_reg != LINE_MAX)
                    line_next = line_reg + 1'b1;
                column_next = COLUMN_BITS'(1);
            end else if (column_reg != COLUMN_MAX) begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    // pack the word's tokens in order, flag the final one
    always_comb
    begin
        push_n     = {1'b0, tok_a_vld} + {1'b0, tok_b_vld};
        first_tok  = tok_a_vld ? tok_a : tok_b;
        second_tok = tok_b;
        if (push_n == 2'd2)
            second_tok.last = 1'b1;
        else
            first_tok.last = 1'b1;
        if (!accept)
            push_n = 2'd0;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= M_IDLE;
            line_reg       <= LINE_BITS'(1);
            column_reg     <= COLUMN_BITS'(1);
            offset_reg     <= '0;
            tok_line_reg   <= LINE_BITS'(1);
            tok_column_reg <= COLUMN_BITS'(1);
            tok_offset_reg <= '0;
            wbuf_reg       <= '0;
            wlen_reg       <= '0;
            pending_reg    <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (accept) begin
                mode_reg       <= mode_next;
                line_reg       <= line_next;
                column_reg     <= column_next;
                offset_reg     <= offset_next;
                tok_line_reg   <= tok_line_next;
                tok_column_reg <= tok_column_next;
                tok_offset_reg <= tok_offset_next;
                wbuf_reg       <= wbuf_next;
                wlen_reg       <= wlen_next;
                pending_reg    <= pending_next;
                if (push_n != 2'd0)
                    queue_reg[wr_ptr_reg] <= first_tok;
                if (push_n == 2'd2)
                    queue_reg[wr_ptr_reg + 1'b1] <= second_tok;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign item_ready   = count_reg <= CNT_ROOM2;
    assign token_valid  = count_reg != '0;
    assign head         = queue_reg[rd_ptr_reg];
    assign token_kind   = head.kind;
    assign start_line   = head.line;
    assign start_column = head.column;
    assign text_offset  = head.offset;
    assign text_length  = head.length;
    assign short_text   = head.text;
    assign last         = head.last;

    `STT_ASSERT_ALWAYS(a_queue_bound, count_reg <= CNT_FULL)
    `STT_ASSERT_NEXT(a_eof_idle, accept && action, mode_reg == M_IDLE)
    `STT_ASSERT_NEXT(a_eof_queued, accept && action, count_reg != '0)

endmodule
